// ===== src/fsla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsla_pkg
// Shared types and constants of the free-list slot allocator.
// ----------------------------------------------------------------------------
package fsla_pkg;

  // pool geometry
  localparam int SLOT_COUNT = 256;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int COUNT_W    = $clog2(SLOT_COUNT + 1);

  // fixed field widths of the channels
  localparam int CMD_W     = 2;
  localparam int SLOT_IN_W = 16;
  localparam int GRANT_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int LIVE_W    = 9;
  localparam int CAP_W     = 9;

  // capacity register value after reset
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_ALLOC,
    S_FREE,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic [GRANT_W-1:0] granted;
    status_t            status;
    logic [LIVE_W-1:0]  live;
  } result_t;

  // free stack memory access
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] wdata;
    logic [SLOT_W-1:0] raddr;
  } stack_req_t;

  // active flag memory access
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic              wdata;
    logic [SLOT_W-1:0] raddr;
  } flag_req_t;

endpackage

// ===== src/fsla_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsla_if
// Valid/ready channels of the allocator: commands, results, capacity writes.
// ----------------------------------------------------------------------------
interface fsla_item_if;
  logic                            valid;
  logic                            ready;
  logic [fsla_pkg::CMD_W-1:0]      command;
  logic [fsla_pkg::SLOT_IN_W-1:0]  slot_to_free;

  modport source (output valid, command, slot_to_free, input ready);
  modport sink   (input valid, command, slot_to_free, output ready);
endinterface

interface fsla_result_if;
  logic                            valid;
  logic                            ready;
  logic [fsla_pkg::GRANT_W-1:0]    granted_slot;
  logic [fsla_pkg::STATUS_W-1:0]   status;
  logic [fsla_pkg::LIVE_W-1:0]     live_count;

  modport source (output valid, granted_slot, status, live_count, input ready);
  modport sink   (input valid, granted_slot, status, live_count, output ready);
endinterface

interface fsla_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [fsla_pkg::CAP_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== src/free_list_slot_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_slot_allocator
// Slot pool managed by a stack of free slot numbers held in RAM.
//
// Usage:
// - items carries one command per beat: allocate, free (slot_to_free) or
//   clear. results returns exactly one beat per command with the granted
//   slot, a status and the number of active slots after the command.
// - cfg writes the capacity in use; clear takes it up, reset uses CAP_RESET.
// - Allocate and free first read the stack or the flag RAM, then write
//   back and register the result. An empty allocate, a rejected free or
//   an unknown command answers straight from the idle state.
// - Clear rewrites all 256 entries of both RAMs, one entry per cycle, then
//   answers. After reset the same sweep runs, with no result; items.ready
//   stays low until it ends, while cfg writes are taken at any time.
// - A result waits in the output register while the receiver stalls; the
//   next command is still accepted, and a second finished result is held
//   internally until the output register frees up.
// ----------------------------------------------------------------------------
module free_list_slot_allocator (
  input  logic          clk,
  input  logic          rst,
  fsla_item_if.sink     items,
  fsla_result_if.source results,
  fsla_cfg_if.sink      cfg
);

  logic [fsla_pkg::CAP_W-1:0]  cap_cfg_q;
  fsla_pkg::stack_req_t        stack_req;
  fsla_pkg::flag_req_t         flag_req;
  logic [fsla_pkg::SLOT_W-1:0] stack_rdata;
  logic                        flag_rdata;

  // capacity register, always writable
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_cfg_q <= fsla_pkg::CAP_RESET;
    end else if (cfg.valid) begin
      cap_cfg_q <= cfg.data;
    end
  end

  // free slot stack
  fsla_ram #(
    .WIDTH (fsla_pkg::SLOT_W),
    .DEPTH (fsla_pkg::SLOT_COUNT)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stack_req.we),
    .waddr (stack_req.waddr),
    .wdata (stack_req.wdata),
    .raddr (stack_req.raddr),
    .rdata (stack_rdata)
  );

  // per-slot active flags
  fsla_ram #(
    .WIDTH (1),
    .DEPTH (fsla_pkg::SLOT_COUNT)
  ) u_flag_ram (
    .clk   (clk),
    .we    (flag_req.we),
    .waddr (flag_req.waddr),
    .wdata (flag_req.wdata),
    .raddr (flag_req.raddr),
    .rdata (flag_rdata)
  );

  // command sequencer
  fsla_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .items       (items),
    .results     (results),
    .cap_cfg     (cap_cfg_q),
    .stack_req   (stack_req),
    .stack_rdata (stack_rdata),
    .flag_req    (flag_req),
    .flag_rdata  (flag_rdata)
  );

endmodule

// ===== src/fsla_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsla_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fsla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== src/fsla_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsla_ctrl
// Command sequencer: pops and pushes the free stack, updates active flags,
// runs the rebuild sweep and owns the result register.
// ----------------------------------------------------------------------------
module fsla_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  fsla_item_if.sink                      items,
  fsla_result_if.source                  results,
  input  logic [fsla_pkg::CAP_W-1:0]     cap_cfg,
  output fsla_pkg::stack_req_t           stack_req,
  input  logic [fsla_pkg::SLOT_W-1:0]    stack_rdata,
  output fsla_pkg::flag_req_t            flag_req,
  input  logic                           flag_rdata
);

  localparam int SW = fsla_pkg::SLOT_W;
  localparam int CW = fsla_pkg::COUNT_W;
  localparam logic [CW-1:0] FULL = CW'(fsla_pkg::SLOT_COUNT);
  localparam logic [SW-1:0] LAST = SW'(fsla_pkg::SLOT_COUNT - 1);

  fsla_pkg::state_t  state_q, state_next;
  logic [CW-1:0]     height_q, height_next;
  logic [CW-1:0]     total_q, total_next;
  logic [CW-1:0]     cap_q, cap_next;
  logic [SW-1:0]     ptr_q, ptr_next;
  logic              sweep_resp_q, sweep_resp_next;
  logic [SW-1:0]     slot_q, slot_next;
  fsla_pkg::result_t pend_q;
  fsla_pkg::result_t out_q;
  logic              out_valid_q;

  fsla_pkg::result_t res;
  logic              res_valid;
  logic              out_free;
  logic              sweep_last;
  logic              free_ok;
  logic [CW-1:0]     total_dec;

  // capacity latched into 1..slot count
  function automatic logic [CW-1:0] clamp_cap(input logic [fsla_pkg::CAP_W-1:0] c);
    logic [CW-1:0] r;
    r = CW'(c);
    if (c == '0) begin
      r = CW'(1);
    end else if (CW'(c) > FULL) begin
      r = FULL;
    end
    return r;
  endfunction

  assign out_free   = !out_valid_q || results.ready;
  assign sweep_last = (ptr_q == LAST);
  assign free_ok    = (items.slot_to_free < fsla_pkg::SLOT_IN_W'(cap_q)) &&
                      (height_q < FULL);
  assign total_dec  = (total_q != '0) ? total_q - CW'(1) : total_q;
  assign items.ready = (state_q == fsla_pkg::S_IDLE);

  // next state
  always_comb begin
    state_next = state_q;
    case (state_q)
      fsla_pkg::S_SWEEP: begin
        if (sweep_last) begin
          state_next = (res_valid && !out_free) ? fsla_pkg::S_HOLD : fsla_pkg::S_IDLE;
        end
      end
      fsla_pkg::S_IDLE: begin
        if (items.valid) begin
          case (fsla_pkg::cmd_t'(items.command))
            fsla_pkg::CMD_ALLOC: if (height_q != '0) state_next = fsla_pkg::S_ALLOC;
            fsla_pkg::CMD_FREE:  if (free_ok) state_next = fsla_pkg::S_FREE;
            fsla_pkg::CMD_CLEAR: state_next = fsla_pkg::S_SWEEP;
            default: ;
          endcase
          if (res_valid && !out_free) begin
            state_next = fsla_pkg::S_HOLD;
          end
        end
      end
      fsla_pkg::S_ALLOC,
      fsla_pkg::S_FREE: begin
        state_next = out_free ? fsla_pkg::S_IDLE : fsla_pkg::S_HOLD;
      end
      fsla_pkg::S_HOLD: begin
        if (out_free) state_next = fsla_pkg::S_IDLE;
      end
      default: state_next = fsla_pkg::S_IDLE;
    endcase
  end

  // memory accesses, register updates and result
  always_comb begin
    stack_req       = '0;
    flag_req        = '0;
    res_valid       = 1'b0;
    res             = '{granted: '0, status: fsla_pkg::ST_DONE, live: total_q};
    height_next     = height_q;
    total_next      = total_q;
    cap_next        = cap_q;
    ptr_next        = ptr_q;
    sweep_resp_next = sweep_resp_q;
    slot_next       = slot_q;
    case (state_q)
      fsla_pkg::S_SWEEP: begin
        // entry i gets slot i, flag cleared
        stack_req.we    = 1'b1;
        stack_req.waddr = ptr_q;
        stack_req.wdata = ptr_q;
        flag_req.we     = 1'b1;
        flag_req.waddr  = ptr_q;
        flag_req.wdata  = 1'b0;
        ptr_next        = ptr_q + SW'(1);
        if (sweep_last) begin
          sweep_resp_next = 1'b0;
          res_valid       = sweep_resp_q;
          res.live        = '0;
        end
      end
      fsla_pkg::S_IDLE: begin
        if (items.valid) begin
          case (fsla_pkg::cmd_t'(items.command))
            fsla_pkg::CMD_ALLOC: begin
              if (height_q == '0) begin
                res_valid  = 1'b1;
                res.status = fsla_pkg::ST_EMPTY;
              end else begin
                stack_req.raddr = SW'(height_q - CW'(1));
                height_next     = height_q - CW'(1);
              end
            end
            fsla_pkg::CMD_FREE: begin
              if (free_ok) begin
                flag_req.raddr = items.slot_to_free[SW-1:0];
                slot_next      = items.slot_to_free[SW-1:0];
              end else begin
                res_valid  = 1'b1;
                res.status = fsla_pkg::ST_IGNORED;
              end
            end
            fsla_pkg::CMD_CLEAR: begin
              cap_next        = clamp_cap(cap_cfg);
              height_next     = clamp_cap(cap_cfg);
              total_next      = '0;
              ptr_next        = '0;
              sweep_resp_next = 1'b1;
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      fsla_pkg::S_ALLOC: begin
        // popped slot becomes active
        flag_req.we    = 1'b1;
        flag_req.waddr = stack_rdata;
        flag_req.wdata = 1'b1;
        total_next     = total_q + CW'(1);
        res_valid      = 1'b1;
        res.granted    = stack_rdata;
        res.live       = total_q + CW'(1);
      end
      fsla_pkg::S_FREE: begin
        res_valid = 1'b1;
        if (flag_rdata) begin
          flag_req.we     = 1'b1;
          flag_req.waddr  = slot_q;
          flag_req.wdata  = 1'b0;
          stack_req.we    = 1'b1;
          stack_req.waddr = height_q[SW-1:0];
          stack_req.wdata = slot_q;
          height_next     = height_q + CW'(1);
          total_next      = total_dec;
          res.live        = total_dec;
        end else begin
          res.status = fsla_pkg::ST_IGNORED;
        end
      end
      fsla_pkg::S_HOLD: begin
        res_valid = 1'b1;
        res       = pend_q;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state_q      <= fsla_pkg::S_SWEEP;
      height_q     <= clamp_cap(fsla_pkg::CAP_RESET);
      total_q      <= '0;
      cap_q        <= clamp_cap(fsla_pkg::CAP_RESET);
      ptr_q        <= '0;
      sweep_resp_q <= 1'b0;
    end else begin
      state_q      <= state_next;
      height_q     <= height_next;
      total_q      <= total_next;
      cap_q        <= cap_next;
      ptr_q        <= ptr_next;
      sweep_resp_q <= sweep_resp_next;
    end
  end

  // payload holding registers
  always_ff @(posedge clk) begin
    slot_q <= slot_next;
    if (res_valid && !out_free) begin
      pend_q <= res;
    end
    if (res_valid && out_free) begin
      out_q <= res;
    end
  end

  // result beat valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && out_free) begin
      out_valid_q <= 1'b1;
    end else if (results.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign results.valid        = out_valid_q;
  assign results.granted_slot = out_q.granted;
  assign results.status       = fsla_pkg::STATUS_W'(out_q.status);
  assign results.live_count   = out_q.live;

endmodule
